/* sv/dcsg_pkg.sv */
// ----------------------------------------------------------------------------
// Doppler clutter sample generator package
// Shared widths, register indexes, reset values and the CORDIC angle table.
// ----------------------------------------------------------------------------
package dcsg_pkg;

    localparam int MAX_PULSES_DEF = 1024;
    localparam int ANGLE_BITS_DEF = 16;

    localparam int SPEED_W  = 16;
    localparam int WAVE_W   = 20;
    localparam int RATE_W   = 20;
    localparam int CFG_W    = 20;
    localparam int CFG_IDX_W = 2;
    localparam int PULSE_W  = 10;
    localparam int IN_ANG_W = 16;
    localparam int POWER_W  = 32;
    localparam int AMP_W    = 16;
    localparam int SAMPLE_W = 16;
    localparam int TRIG_W   = 34;
    localparam int ZANG_W   = 33;

    localparam logic [CFG_IDX_W-1:0] CFG_PLATFORM_SPEED     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CARRIER_WAVELENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_RATE         = 2'd2;

    localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd8000;
    localparam logic [WAVE_W-1:0]  WAVE_RESET  = 20'd30000;
    localparam logic [RATE_W-1:0]  RATE_RESET  = 20'd15000;

    localparam logic [16:0] DOPPLER_SCALE = 17'd125000;

    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;

    localparam int CORDIC_ITERS = 30;
    localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

    localparam logic [31:0] ATAN_TABLE [0:CORDIC_ITERS-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

endpackage

/* sv/dcsg_front.sv */
// ----------------------------------------------------------------------------
// Doppler clutter sample generator front end
// Takes an item, reduces the pulse index to the dwell and resizes the angles.
// ----------------------------------------------------------------------------
module dcsg_front #(
    parameter int MAX_PULSES = dcsg_pkg::MAX_PULSES_DEF,
    parameter int ANGLE_BITS = dcsg_pkg::ANGLE_BITS_DEF,
    parameter int N_W        = 10,
    parameter int ITEM_W     = 90
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [dcsg_pkg::PULSE_W-1:0]        i_pulse_index,
    input  logic signed [dcsg_pkg::IN_ANG_W-1:0] i_patch_azimuth,
    input  logic signed [dcsg_pkg::IN_ANG_W-1:0] i_patch_elevation,
    input  logic [dcsg_pkg::POWER_W-1:0]        i_patch_power,
    input  logic [dcsg_pkg::IN_ANG_W-1:0]       i_start_phase,
    input  logic                                i_full,
    output logic                                o_busy,
    output logic                                o_push,
    output logic [ITEM_W-1:0]                   o_item
);

    localparam int PW = dcsg_pkg::PULSE_W;

    logic              r_vld;
    logic [ITEM_W-1:0] r_item;
    logic [N_W-1:0]    n_idx;
    logic [ANGLE_BITS-1:0] n_az;
    logic [ANGLE_BITS-1:0] n_el;
    logic [ANGLE_BITS-1:0] n_ph;
    logic              take;

    generate
        if (MAX_PULSES >= (2 ** PW)) begin : g_no_mod
            assign n_idx = N_W'(i_pulse_index);
        end else begin : g_mod
            localparam int RECIP = ((2 ** 20) + MAX_PULSES - 1) / MAX_PULSES;
            logic [29:0] prod;
            logic [19:0] qm;
            assign prod  = {20'd0, i_pulse_index} * 30'(RECIP);
            assign qm    = {10'd0, prod[29:20]} * 20'(MAX_PULSES);
            assign n_idx = N_W'({10'd0, i_pulse_index} - qm);
        end
        if (ANGLE_BITS >= 16) begin : g_widen
            assign n_az = {i_patch_azimuth, {(ANGLE_BITS - 16){1'b0}}};
            assign n_el = {i_patch_elevation, {(ANGLE_BITS - 16){1'b0}}};
            assign n_ph = {i_start_phase, {(ANGLE_BITS - 16){1'b0}}};
        end else begin : g_narrow
            assign n_az = i_patch_azimuth[15 -: ANGLE_BITS];
            assign n_el = i_patch_elevation[15 -: ANGLE_BITS];
            assign n_ph = i_start_phase[15 -: ANGLE_BITS];
        end
    endgenerate

    assign o_busy = r_vld && i_full;
    assign o_push = r_vld && !i_full;
    assign o_item = r_item;
    assign take   = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (take) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= {n_idx, n_az, n_el, i_patch_power, n_ph};
        end
    end

endmodule

/* sv/dcsg_queue.sv */
// ----------------------------------------------------------------------------
// Doppler clutter sample generator item queue
// Two-entry queue between the front end and the processing pipeline.
// ----------------------------------------------------------------------------
module dcsg_queue #(
    parameter int W = 90
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    output logic         o_vld,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [0:1];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         pop;

    assign o_full = (r_cnt == 2'd2);
    assign o_vld  = (r_cnt != 2'd0);
    assign o_data = r_mem[r_rp];
    assign pop    = o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

/* sv/dcsg_cordic.sv */
// ----------------------------------------------------------------------------
// Doppler clutter sample generator CORDIC
// Pipelined rotation CORDIC, one iteration per stage, cosine and sine in Q30.
// ----------------------------------------------------------------------------
module dcsg_cordic #(
    parameter int ANGLE_BITS = dcsg_pkg::ANGLE_BITS_DEF,
    parameter int SIDE_W     = 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_vld,
    input  logic [ANGLE_BITS-1:0]             i_angle,
    input  logic [SIDE_W-1:0]                 i_side,
    output logic                              o_vld,
    output logic signed [dcsg_pkg::TRIG_W-1:0] o_cos,
    output logic signed [dcsg_pkg::TRIG_W-1:0] o_sin,
    output logic [SIDE_W-1:0]                 o_side
);

    localparam int N  = dcsg_pkg::CORDIC_ITERS;
    localparam int TW = dcsg_pkg::TRIG_W;
    localparam int ZW = dcsg_pkg::ZANG_W;

    logic [N:0]              r_vld;
    logic signed [TW-1:0]    r_x [0:N];
    logic signed [TW-1:0]    r_y [0:N];
    logic signed [ZW-1:0]    r_z [0:N];
    logic [1:0]              r_quad [0:N];
    logic [SIDE_W-1:0]       r_side [0:N];
    logic                    r_out_vld;
    logic [31:0]             a32;

    assign a32 = {i_angle, {(32 - ANGLE_BITS){1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld     <= {r_vld[N-1:0], i_vld};
            r_out_vld <= r_vld[N];
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]    <= TW'(dcsg_pkg::CORDIC_GAIN);
        r_y[0]    <= '0;
        r_z[0]    <= {3'b000, a32[29:0]};
        r_quad[0] <= a32[31:30];
        r_side[0] <= i_side;
    end

    generate
        for (genvar gi = 0; gi < N; gi++) begin : g_iter
            always_ff @(posedge i_clk) begin
                if (!r_z[gi][ZW-1]) begin
                    r_x[gi+1] <= r_x[gi] - (r_y[gi] >>> gi);
                    r_y[gi+1] <= r_y[gi] + (r_x[gi] >>> gi);
                    r_z[gi+1] <= r_z[gi] - ZW'(dcsg_pkg::ATAN_TABLE[gi]);
                end else begin
                    r_x[gi+1] <= r_x[gi] + (r_y[gi] >>> gi);
                    r_y[gi+1] <= r_y[gi] - (r_x[gi] >>> gi);
                    r_z[gi+1] <= r_z[gi] + ZW'(dcsg_pkg::ATAN_TABLE[gi]);
                end
                r_quad[gi+1] <= r_quad[gi];
                r_side[gi+1] <= r_side[gi];
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        case (r_quad[N])
            dcsg_pkg::QUAD_FIRST: begin
                o_cos <= r_x[N];
                o_sin <= r_y[N];
            end
            dcsg_pkg::QUAD_SECOND: begin
                o_cos <= -r_y[N];
                o_sin <= r_x[N];
            end
            dcsg_pkg::QUAD_THIRD: begin
                o_cos <= -r_x[N];
                o_sin <= -r_y[N];
            end
            default: begin
                o_cos <= r_y[N];
                o_sin <= -r_x[N];
            end
        endcase
        o_side <= r_side[N];
    end

    assign o_vld = r_out_vld;

endmodule

/* sv/dcsg_div.sv */
// ----------------------------------------------------------------------------
// Doppler clutter sample generator divider
// Pipelined restoring divider, one quotient bit per stage, with start remainder.
// ----------------------------------------------------------------------------
module dcsg_div #(
    parameter int Q_W    = 8,
    parameter int D_W    = 8,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [Q_W-1:0]    i_num,
    input  logic [D_W-1:0]    i_rem,
    input  logic [D_W-1:0]    i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [Q_W-1:0]    o_quo,
    output logic [D_W-1:0]    o_rem,
    output logic [SIDE_W-1:0] o_side
);

    logic [Q_W:0]        r_vld;
    logic [D_W-1:0]      r_rem [0:Q_W];
    logic [Q_W-1:0]      r_nq [0:Q_W];
    logic [SIDE_W-1:0]   r_side [0:Q_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[Q_W-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= i_rem;
        r_nq[0]   <= i_num;
        r_side[0] <= i_side;
    end

    generate
        for (genvar gk = 0; gk < Q_W; gk++) begin : g_step
            logic [D_W:0] trial;
            logic         ge;
            assign trial = {r_rem[gk], r_nq[gk][Q_W-1]};
            assign ge    = (trial >= {1'b0, i_den});
            always_ff @(posedge i_clk) begin
                if (ge) begin
                    r_rem[gk+1] <= D_W'(trial - {1'b0, i_den});
                end else begin
                    r_rem[gk+1] <= trial[D_W-1:0];
                end
                r_nq[gk+1]   <= {r_nq[gk][Q_W-2:0], ge};
                r_side[gk+1] <= r_side[gk];
            end
        end
    endgenerate

    assign o_vld  = r_vld[Q_W];
    assign o_quo  = r_nq[Q_W];
    assign o_rem  = r_rem[Q_W];
    assign o_side = r_side[Q_W];

endmodule

/* sv/dcsg_back.sv */
// ----------------------------------------------------------------------------
// Doppler clutter sample generator back end
// Amplitude, Doppler phase and the output rotation, fully pipelined.
// ----------------------------------------------------------------------------
module dcsg_back #(
    parameter int ANGLE_BITS = dcsg_pkg::ANGLE_BITS_DEF,
    parameter int N_W        = 10,
    parameter int ITEM_W     = 90
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_vld,
    input  logic [ITEM_W-1:0]                   i_item,
    input  logic [dcsg_pkg::SPEED_W-1:0]        i_speed,
    input  logic [dcsg_pkg::WAVE_W-1:0]         i_wave,
    input  logic [dcsg_pkg::RATE_W-1:0]         i_rate,
    output logic                                o_valid,
    output logic signed [dcsg_pkg::SAMPLE_W-1:0] o_sample_i,
    output logic signed [dcsg_pkg::SAMPLE_W-1:0] o_sample_q
);

    localparam int AB   = ANGLE_BITS;
    localparam int TW   = dcsg_pkg::TRIG_W;
    localparam int AW   = dcsg_pkg::AMP_W;
    localparam int PWW  = dcsg_pkg::POWER_W;
    localparam int SQ_N = PWW / 2;
    localparam int S1_W = N_W + 3 * AB;
    localparam int S2_W = N_W + AB + AW;
    localparam int S3_W = S2_W + 1;
    localparam int FQ_W = 50;
    localparam int FN_W = FQ_W + N_W;
    localparam int D2_W = FN_W - 16;
    localparam int S4_W = AB + AW + 1 + 16;
    localparam int S5_W = AB + AW + 1;
    localparam int D3_W = dcsg_pkg::RATE_W + 16;
    localparam int PR_W = AW + 1 + TW;

    // Square root of the power, two bits of the radicand per stage.
    logic [SQ_N:0]     r_sq_vld;
    logic [PWW-1:0]    r_sq_val [0:SQ_N];
    logic [AW+1:0]     r_sq_rem [0:SQ_N];
    logic [AW-1:0]     r_sq_root [0:SQ_N];
    logic [S1_W-1:0]   r_sq_side [0:SQ_N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld <= '0;
        end else begin
            r_sq_vld <= {r_sq_vld[SQ_N-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_val[0]  <= i_item[AB +: PWW];
        r_sq_rem[0]  <= '0;
        r_sq_root[0] <= '0;
        r_sq_side[0] <= {i_item[ITEM_W-1 -: N_W + 2 * AB], i_item[AB-1:0]};
    end

    generate
        for (genvar gs = 0; gs < SQ_N; gs++) begin : g_sqrt
            logic [AW+3:0] cur;
            logic [AW+3:0] trial;
            assign cur   = {r_sq_rem[gs], r_sq_val[gs][PWW-1 -: 2]};
            assign trial = {2'b00, r_sq_root[gs], 2'b01};
            always_ff @(posedge i_clk) begin
                if (cur >= trial) begin
                    r_sq_rem[gs+1]  <= (AW+2)'(cur - trial);
                    r_sq_root[gs+1] <= {r_sq_root[gs][AW-2:0], 1'b1};
                end else begin
                    r_sq_rem[gs+1]  <= (AW+2)'(cur);
                    r_sq_root[gs+1] <= {r_sq_root[gs][AW-2:0], 1'b0};
                end
                r_sq_val[gs+1]  <= {r_sq_val[gs][PWW-3:0], 2'b00};
                r_sq_side[gs+1] <= r_sq_side[gs];
            end
        end
    endgenerate

    // Direction cosines of the patch.
    logic [N_W-1:0]  sq_n;
    logic [AB-1:0]   sq_az;
    logic [AB-1:0]   sq_el;
    logic [AB-1:0]   sq_ph;
    logic            ca_vld;
    logic signed [TW-1:0] ca_cos;
    logic signed [TW-1:0] ce_cos;
    logic [S2_W-1:0] ca_side;

    assign {sq_n, sq_az, sq_el, sq_ph} = r_sq_side[SQ_N];

    dcsg_cordic #(.ANGLE_BITS(AB), .SIDE_W(S2_W)) u_cordic_az (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_sq_vld[SQ_N]),
        .i_angle (sq_az),
        .i_side  ({sq_n, sq_ph, r_sq_root[SQ_N]}),
        .o_vld   (ca_vld),
        .o_cos   (ca_cos),
        .o_sin   (),
        .o_side  (ca_side)
    );

    dcsg_cordic #(.ANGLE_BITS(AB), .SIDE_W(1)) u_cordic_el (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_sq_vld[SQ_N]),
        .i_angle (sq_el),
        .i_side  (1'b0),
        .o_vld   (),
        .o_cos   (ce_cos),
        .o_sin   (),
        .o_side  ()
    );

    // Doppler magnitude numerator.
    logic [3:0]              r_m_vld;
    logic signed [2*TW-1:0]  r_cc_prod;
    logic [S2_W-1:0]         r_side_m1;
    logic [30:0]             r_m;
    logic                    r_pos_m2;
    logic [S2_W-1:0]         r_side_m2;
    logic [46:0]             r_vm;
    logic                    r_pos_m3;
    logic [S2_W-1:0]         r_side_m3;
    logic [63:0]             r_num;
    logic                    r_pos_m4;
    logic [S2_W-1:0]         r_side_m4;
    logic signed [2*TW-1:0]  cc_full;
    logic [2*TW-1:0]         cc_mag;
    logic                    cc_pos;
    logic [30:0]             cc_m;
    logic [dcsg_pkg::WAVE_W-1:0] wave_eff;
    logic [dcsg_pkg::RATE_W-1:0] rate_eff;

    assign cc_full = (r_cc_prod + (2*TW)'(64'sh2000_0000)) >>> 30;
    assign cc_mag  = cc_full[2*TW-1] ? (2*TW)'(-cc_full) : (2*TW)'(cc_full);
    assign cc_pos  = !cc_full[2*TW-1] && (cc_full != '0);
    assign cc_m    = (cc_mag > (2*TW)'(64'h4000_0000)) ? 31'h4000_0000 : cc_mag[30:0];
    assign wave_eff = (i_wave == '0) ? dcsg_pkg::WAVE_W'(1) : i_wave;
    assign rate_eff = (i_rate == '0) ? dcsg_pkg::RATE_W'(1) : i_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= '0;
        end else begin
            r_m_vld <= {r_m_vld[2:0], ca_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_cc_prod <= ca_cos * ce_cos;
        r_side_m1 <= ca_side;
        r_m       <= cc_m;
        r_pos_m2  <= cc_pos;
        r_side_m2 <= r_side_m1;
        r_vm      <= {31'd0, i_speed} * {16'd0, r_m};
        r_pos_m3  <= r_pos_m2;
        r_side_m3 <= r_side_m2;
        r_num     <= {17'd0, r_vm} * {47'd0, dcsg_pkg::DOPPLER_SCALE};
        r_pos_m4  <= r_pos_m3;
        r_side_m4 <= r_side_m3;
    end

    // Doppler frequency, then its phase over n pulses.
    logic            d1_vld;
    logic [FQ_W-1:0] d1_quo;
    logic [S3_W-1:0] d1_side;

    dcsg_div #(.Q_W(FQ_W), .D_W(dcsg_pkg::WAVE_W), .SIDE_W(S3_W)) u_div_freq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_m_vld[3]),
        .i_num   (r_num[63:14]),
        .i_rem   ('0),
        .i_den   (wave_eff),
        .i_side  ({r_side_m4, r_pos_m4}),
        .o_vld   (d1_vld),
        .o_quo   (d1_quo),
        .o_rem   (),
        .o_side  (d1_side)
    );

    logic [N_W-1:0]  d1_n;
    logic [AB-1:0]   d1_ph;
    logic [AW-1:0]   d1_amp;
    logic            d1_pos;
    logic            r_fn_vld;
    logic [FN_W-1:0] r_fn;
    logic [S5_W-1:0] r_side_m5;

    assign {d1_n, d1_ph, d1_amp, d1_pos} = d1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fn_vld <= 1'b0;
        end else begin
            r_fn_vld <= d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fn      <= FN_W'(d1_quo) * FN_W'(d1_n);
        r_side_m5 <= {d1_ph, d1_amp, d1_pos};
    end

    logic                        d2_vld;
    logic [dcsg_pkg::RATE_W-1:0] d2_rem;
    logic [S4_W-1:0]             d2_side;

    dcsg_div #(.Q_W(D2_W), .D_W(dcsg_pkg::RATE_W), .SIDE_W(S4_W)) u_div_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_fn_vld),
        .i_num   (r_fn[FN_W-1:16]),
        .i_rem   ('0),
        .i_den   (rate_eff),
        .i_side  ({r_side_m5, r_fn[15:0]}),
        .o_vld   (d2_vld),
        .o_quo   (),
        .o_rem   (d2_rem),
        .o_side  (d2_side)
    );

    logic            d3_vld;
    logic [AB-1:0]   d3_quo;
    logic [S5_W-1:0] d3_side;

    dcsg_div #(.Q_W(AB), .D_W(D3_W), .SIDE_W(S5_W)) u_div_frac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (d2_vld),
        .i_num   ('0),
        .i_rem   ({d2_rem, d2_side[15:0]}),
        .i_den   ({rate_eff, 16'd0}),
        .i_side  (d2_side[S4_W-1:16]),
        .o_vld   (d3_vld),
        .o_quo   (d3_quo),
        .o_rem   (),
        .o_side  (d3_side)
    );

    // Sample phase and output rotation.
    logic [AB-1:0] d3_ph;
    logic [AW-1:0] d3_amp;
    logic          d3_pos;
    logic [AB-1:0] phase;

    assign {d3_ph, d3_amp, d3_pos} = d3_side;
    assign phase = (d3_pos ? AB'(-d3_quo) : d3_quo) + d3_ph;

    logic                 cx_vld;
    logic signed [TW-1:0] cx_cos;
    logic signed [TW-1:0] cx_sin;
    logic [AW-1:0]        cx_amp;

    dcsg_cordic #(.ANGLE_BITS(AB), .SIDE_W(AW)) u_cordic_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (d3_vld),
        .i_angle (phase),
        .i_side  (d3_amp),
        .o_vld   (cx_vld),
        .o_cos   (cx_cos),
        .o_sin   (cx_sin),
        .o_side  (cx_amp)
    );

    logic                   r_p_vld;
    logic signed [PR_W-1:0] r_prod_i;
    logic signed [PR_W-1:0] r_prod_q;
    logic                   r_out_vld;
    logic signed [PR_W-1:0] rnd_i;
    logic signed [PR_W-1:0] rnd_q;
    logic signed [AW+1:0]   amp_s;

    assign amp_s = $signed({2'b00, cx_amp});
    assign rnd_i = (r_prod_i + PR_W'(64'sh4000_0000)) >>> 31;
    assign rnd_q = (r_prod_q + PR_W'(64'sh4000_0000)) >>> 31;

    function automatic logic signed [dcsg_pkg::SAMPLE_W-1:0] sat16(
        input logic signed [PR_W-1:0] v
    );
        logic signed [dcsg_pkg::SAMPLE_W-1:0] r;
        if (v > PR_W'(32767)) begin
            r = 16'sh7FFF;
        end else if (v < -PR_W'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = v[dcsg_pkg::SAMPLE_W-1:0];
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_p_vld   <= cx_vld;
            r_out_vld <= r_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod_i   <= PR_W'(amp_s) * PR_W'(cx_cos);
        r_prod_q   <= PR_W'(amp_s) * PR_W'(-cx_sin);
        o_sample_i <= sat16(rnd_i);
        o_sample_q <= sat16(rnd_q);
    end

    assign o_valid = r_out_vld;

endmodule

/* sv/doppler_clutter_sample_gen_unit.sv */
// ----------------------------------------------------------------------------
// Doppler clutter sample generator
// Turns a clutter patch and pulse index into one saturated complex I/Q sample.
// ----------------------------------------------------------------------------
// The sample path runs through the three CORDIC pipelines and the bit-per-stage dividers.
// Throughput is one item per clock; busy stays low because results are never held.
// Each result is shown for exactly one cycle on o_valid.
// Reset is synchronous: it clears all valid bits and reloads the registers.
// ----------------------------------------------------------------------------
module doppler_clutter_sample_gen_unit #(
    parameter int MAX_PULSES = dcsg_pkg::MAX_PULSES_DEF,
    parameter int ANGLE_BITS = dcsg_pkg::ANGLE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_cfg_we,
    input  logic [dcsg_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [dcsg_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic [dcsg_pkg::PULSE_W-1:0]         i_pulse_index,
    input  logic signed [dcsg_pkg::IN_ANG_W-1:0] i_patch_azimuth,
    input  logic signed [dcsg_pkg::IN_ANG_W-1:0] i_patch_elevation,
    input  logic [dcsg_pkg::POWER_W-1:0]         i_patch_power,
    input  logic [dcsg_pkg::IN_ANG_W-1:0]        i_start_phase,
    output logic                                 o_valid,
    output logic signed [dcsg_pkg::SAMPLE_W-1:0] o_sample_i,
    output logic signed [dcsg_pkg::SAMPLE_W-1:0] o_sample_q
);

    localparam int N_W    = (MAX_PULSES >= (2 ** dcsg_pkg::PULSE_W)) ?
                            dcsg_pkg::PULSE_W : $clog2(MAX_PULSES);
    localparam int ITEM_W = N_W + 3 * ANGLE_BITS + dcsg_pkg::POWER_W;

    logic [dcsg_pkg::SPEED_W-1:0] r_speed;
    logic [dcsg_pkg::WAVE_W-1:0]  r_wave;
    logic [dcsg_pkg::RATE_W-1:0]  r_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= dcsg_pkg::SPEED_RESET;
            r_wave  <= dcsg_pkg::WAVE_RESET;
            r_rate  <= dcsg_pkg::RATE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dcsg_pkg::CFG_PLATFORM_SPEED:     r_speed <= i_cfg_data[15:0];
                dcsg_pkg::CFG_CARRIER_WAVELENGTH: r_wave  <= i_cfg_data;
                dcsg_pkg::CFG_PULSE_RATE:         r_rate  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    logic              q_full;
    logic              f_push;
    logic [ITEM_W-1:0] f_item;
    logic              q_vld;
    logic [ITEM_W-1:0] q_item;

    dcsg_front #(
        .MAX_PULSES (MAX_PULSES),
        .ANGLE_BITS (ANGLE_BITS),
        .N_W        (N_W),
        .ITEM_W     (ITEM_W)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_pulse_index     (i_pulse_index),
        .i_patch_azimuth   (i_patch_azimuth),
        .i_patch_elevation (i_patch_elevation),
        .i_patch_power     (i_patch_power),
        .i_start_phase     (i_start_phase),
        .i_full            (q_full),
        .o_busy            (busy),
        .o_push            (f_push),
        .o_item            (f_item)
    );

    dcsg_queue #(.W(ITEM_W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_item),
        .o_full  (q_full),
        .o_vld   (q_vld),
        .o_data  (q_item)
    );

    dcsg_back #(
        .ANGLE_BITS (ANGLE_BITS),
        .N_W        (N_W),
        .ITEM_W     (ITEM_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (q_vld),
        .i_item     (q_item),
        .i_speed    (r_speed),
        .i_wave     (r_wave),
        .i_rate     (r_rate),
        .o_valid    (o_valid),
        .o_sample_i (o_sample_i),
        .o_sample_q (o_sample_q)
    );

endmodule

/* bench/doppler_clutter_sample_gen_unit_test.sv */
// ----------------------------------------------------------------------------
// Doppler clutter sample generator unit test
// Drives patch and pulse items through the command port under several register
// settings and compares every I/Q sample with an in-bench bit-exact predictor.
// ----------------------------------------------------------------------------
module doppler_clutter_sample_gen_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import dcsg_pkg::*;

    localparam int LATENCY    = 203;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM   = 1000;

    typedef struct {
        logic [PULSE_W-1:0]         pulse;
        logic signed [IN_ANG_W-1:0] az;
        logic signed [IN_ANG_W-1:0] el;
        logic [POWER_W-1:0]         power;
        logic [IN_ANG_W-1:0]        phase;
    } patch_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] si;
        logic signed [SAMPLE_W-1:0] sq;
    } iq_t;

    class iq_scoreboard;
        iq_t                 iq_pending[$];
        int                  errors = 0;
        int                  matched = 0;
        logic [SPEED_W-1:0]  speed = SPEED_RESET;
        logic [WAVE_W-1:0]   wave = WAVE_RESET;
        logic [RATE_W-1:0]   rate = RATE_RESET;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_PLATFORM_SPEED: speed = data[SPEED_W-1:0];
                CFG_CARRIER_WAVELENGTH: wave = data;
                CFG_PULSE_RATE: rate = data;
                default: ;
            endcase
        endfunction

        function void rotate(logic [15:0] ang, output longint c, output longint s);
            logic [31:0] a32;
            longint x, y, z, nx, ny;
            a32 = {ang, 16'h0};
            z = longint'(a32[29:0]);
            x = longint'(CORDIC_GAIN);
            y = 0;
            for (int i = 0; i < CORDIC_ITERS; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i);
                    ny = y + (x >>> i);
                    z -= longint'(ATAN_TABLE[i]);
                end else begin
                    nx = x + (y >>> i);
                    ny = y - (x >>> i);
                    z += longint'(ATAN_TABLE[i]);
                end
                x = nx;
                y = ny;
            end
            case (a32[31:30])
                QUAD_FIRST: begin c = x; s = y; end
                QUAD_SECOND: begin c = -y; s = x; end
                QUAD_THIRD: begin c = -x; s = -y; end
                default: begin c = y; s = -x; end
            endcase
        endfunction

        function longint root_floor(longint unsigned v);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 30;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return longint'(res);
        endfunction

        function logic signed [15:0] scale(longint amp, longint trig);
            longint v;
            v = (amp * trig + (64'sd1 <<< 30)) >>> 31;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return v[15:0];
        endfunction

        function void note(patch_t p);
            longint ca, sa, ce, se, cx, sx, cc, amp;
            longint unsigned m, lam, prf, fq, rq, rem, d;
            logic [15:0] x;
            iq_t r;
            rotate(p.az, ca, sa);
            rotate(p.el, ce, se);
            cc = (ca * ce + (64'sd1 <<< 29)) >>> 30;
            m = cc < 0 ? -cc : cc;
            if (m > (64'd1 << 30)) m = 64'd1 << 30;
            lam = wave == 0 ? 1 : wave;
            prf = rate == 0 ? 1 : rate;
            fq = (64'(speed) * m * 64'd125000) / (lam << 14);
            rq = prf << 16;
            rem = (fq * 64'(p.pulse)) % rq;
            d = (rem << 16) / rq;
            if (cc > 0) d = 64'd0 - d;
            x = 16'(d + 64'(p.phase));
            rotate(x, cx, sx);
            amp = root_floor(64'(p.power));
            r.si = scale(amp, cx);
            r.sq = scale(amp, -sx);
            iq_pending = {iq_pending, r};
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check(logic signed [15:0] si, logic signed [15:0] sq);
            iq_t e;
            if (iq_pending.size() == 0) begin
                report($sformatf("unexpected sample i=%0d q=%0d", si, sq));
            end else begin
                e = iq_pending.pop_front();
                if (si !== e.si) report($sformatf("sample_i %0d, want %0d", si, e.si));
                if (sq !== e.sq) report($sformatf("sample_q %0d, want %0d", sq, e.sq));
                if (si === e.si && sq === e.sq) matched++;
            end
        endtask
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic                         i_cfg_we;
    logic [CFG_IDX_W-1:0]         i_cfg_index;
    logic [CFG_W-1:0]             i_cfg_data;
    logic [PULSE_W-1:0]           i_pulse_index;
    logic signed [IN_ANG_W-1:0]   i_patch_azimuth;
    logic signed [IN_ANG_W-1:0]   i_patch_elevation;
    logic [POWER_W-1:0]           i_patch_power;
    logic [IN_ANG_W-1:0]          i_start_phase;
    logic                         o_valid;
    logic signed [SAMPLE_W-1:0]   o_sample_i;
    logic signed [SAMPLE_W-1:0]   o_sample_q;

    iq_scoreboard board = new();
    int cycles = 0;
    int sent = 0;
    int settings = 0;

    doppler_clutter_sample_gen_unit i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) board.check(o_sample_i, o_sample_q);
    end

    // Each task starts and ends just after a rising edge.
    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.set_reg(idx, data);
    endtask

    task configure(logic [CFG_W-1:0] v, logic [CFG_W-1:0] l, logic [CFG_W-1:0] r);
        write_reg(CFG_PLATFORM_SPEED, v);
        write_reg(CFG_CARRIER_WAVELENGTH, l);
        write_reg(CFG_PULSE_RATE, r);
        write_reg(2'd3, CFG_W'($urandom));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        settings++;
    endtask

    task send(patch_t p);
        start <= 1'b1;
        i_pulse_index <= p.pulse;
        i_patch_azimuth <= p.az;
        i_patch_elevation <= p.el;
        i_patch_power <= p.power;
        i_start_phase <= p.phase;
        do @(posedge i_clk); while (busy);
        board.note(p);
        sent++;
    endtask

    task idle(int n);
        start <= 1'b0;
        i_patch_power <= $urandom;
        repeat (n) @(posedge i_clk);
    endtask

    task drain;
        idle(1);
        while (board.iq_pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
    endtask

    function patch_t random_patch();
        patch_t p;
        p.pulse = PULSE_W'($urandom);
        p.az = IN_ANG_W'($urandom);
        p.el = IN_ANG_W'($urandom);
        p.power = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3)
                                              : $urandom;
        p.phase = IN_ANG_W'($urandom);
        return p;
    endfunction

    task random_run(int count);
        int burst;
        for (int k = 0; k < count; k += burst) begin
            burst = $urandom_range(1, 40);
            for (int j = 0; j < burst; j++) send(random_patch());
            if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 6));
        end
    endtask

    initial begin
        patch_t p;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        i_pulse_index <= '0;
        i_patch_azimuth <= '0;
        i_patch_elevation <= '0;
        i_patch_power <= '0;
        i_start_phase <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items at the reset settings: field extremes and saturation.
        send('{10'd0, 16'sd0, 16'sd0, 32'hFFFF_FFFF, 16'd0});
        send('{10'd1023, 16'sd0, 16'sd0, 32'hFFFF_FFFF, 16'hFFFF});
        send('{10'd1023, 16'sd16384, 16'sd0, 32'h4000_0000, 16'd16384});
        send('{10'd512, -16'sd32768, 16'sd0, 32'h8000_0000, 16'd32768});
        send('{10'd777, 16'sd32767, -16'sd32768, 32'd0, 16'd8192});
        send('{10'd1, 16'sd0, 16'sd16384, 32'hFFFF_FFFF, 16'd49152});
        send('{10'd300, -16'sd16384, 16'sd32767, 32'hFFFE_0001, 16'd24576});
        send('{10'h2AA, 16'sh5555, -16'sh5556, 32'hAAAA_AAAA, 16'h5555});
        send('{10'h155, -16'sh5556, 16'sh5555, 32'h5555_5555, 16'hAAAA});
        drain();

        // Fast platform, shortest wavelength, slowest rate.
        configure(20'hFFFFF, 20'd1, 20'd1);
        for (int k = 0; k < 6; k++) begin
            p = random_patch();
            p.pulse = (k == 0) ? 10'd1023 : p.pulse;
            send(p);
        end
        drain();
        // Zero wavelength and zero rate are taken as one.
        configure(20'd40000, 20'd0, 20'd0);
        for (int k = 0; k < 5; k++) send(random_patch());
        drain();
        configure(20'd0, 20'd1000000, 20'd1000000);
        for (int k = 0; k < 4; k++) send(random_patch());
        drain();

        configure(SPEED_RESET, WAVE_RESET, RATE_RESET);
        random_run(N_RANDOM / 5);
        // Hold off until the pipeline has emptied, then carry on.
        idle(1);
        while (board.iq_pending.size() != 0) @(posedge i_clk);
        random_run(N_RANDOM / 5);
        drain();
        configure(20'hFFFF, 20'd1, 20'd1000000);
        random_run(N_RANDOM / 5);
        drain();
        configure(20'd3000, 20'd1000000, 20'd1);
        random_run(N_RANDOM / 5);
        drain();
        configure(CFG_W'($urandom), CFG_W'($urandom_range(1, 1000000)),
                  CFG_W'($urandom_range(1, 1000000)));
        random_run(N_RANDOM / 5);
        drain();

        if (board.iq_pending.size() != 0)
            board.report($sformatf("%0d samples never arrived", board.iq_pending.size()));
        $display("Sent %0d items under %0d register settings; %0d samples matched.",
                 sent, settings + 1, board.matched);
        if (board.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
